@@ rtl/core/bvs_pkg.sv @@
package bvs_pkg;

    localparam int unsigned VENUES_DEF  = 16;
    localparam int unsigned FIELD_W     = 32;
    localparam int unsigned LIQ_WEIGHT  = 1000;
    localparam int unsigned LAT_WEIGHT  = 100;
    localparam int unsigned LIQ_PROD_W  = 42;   // 32 bits times 1000
    localparam int unsigned LAT_PROD_W  = 39;   // 32 bits times 100
    localparam int unsigned SCORE_W     = 44;   // signed balanced score

    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    typedef enum logic [1:0] {
        STRAT_PRICE    = 2'd0,
        STRAT_COST     = 2'd1,
        STRAT_LATENCY  = 2'd2,
        STRAT_BALANCED = 2'd3
    } t_strategy;

    typedef struct packed {
        logic               available;
        logic [FIELD_W-1:0] fees;
        logic [FIELD_W-1:0] latency;
        logic [FIELD_W-1:0] liquidity;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic start;    // clear the running best and the scan address
        logic step;     // read one table entry and advance the address
        logic write;    // write the incoming update beat into the table
        logic load;     // move the final best into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;     // scan address points at the last entry
        logic busy;     // compare pipeline still holds entries
        logic out_free; // output register can take a result this cycle
    } t_dp_sts;

endpackage

@@ rtl/core/bvs_ctrl.sv @@
module bvs_ctrl
    import bvs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_func,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && (i_func == FUNC_SELECT)) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end else if (i_in_valid) begin
                    o_cmd.write = 1'b1;
                end
            end
            ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // wait for the last compare, then for room at the output
                if (!i_sts.busy && i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/bvs_dp.sv @@
module bvs_dp
    import bvs_pkg::*;
#(
    parameter int unsigned VENUES = VENUES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_strategy,
    input  logic [3:0]         i_venue_index,
    input  logic               i_venue_available,
    input  logic [FIELD_W-1:0] i_venue_fees,
    input  logic [FIELD_W-1:0] i_venue_latency,
    input  logic [FIELD_W-1:0] i_venue_liquidity,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [3:0]         o_best_index,
    output logic               o_found
);

    localparam int unsigned IDX_W = (VENUES > 1) ? $clog2(VENUES) : 1;

    t_entry             r_mem [VENUES];
    logic [VENUES-1:0]  r_present;
    t_strategy          r_strategy;

    logic [IDX_W+3:0]   w_wr_wide;
    logic [IDX_W-1:0]   w_wr_addr;
    logic               w_wr_en;

    logic [IDX_W-1:0]   r_addr;

    // stage 1: table read
    logic               r_s1_valid;
    logic               r_s1_present;
    logic [IDX_W-1:0]   r_s1_idx;
    t_entry             r_s1_ent;

    // stage 2: weighted terms
    logic               r_s2_valid;
    logic               r_s2_present;
    logic               r_s2_avail;
    logic [IDX_W-1:0]   r_s2_idx;
    logic [FIELD_W-1:0] r_s2_fees;
    logic [FIELD_W-1:0] r_s2_lat;
    logic [LIQ_PROD_W-1:0] r_s2_liq_w;
    logic [LAT_PROD_W-1:0] r_s2_lat_w;

    // stage 3: score
    logic               r_s3_valid;
    logic               r_s3_present;
    logic               r_s3_avail;
    logic [IDX_W-1:0]   r_s3_idx;
    logic [FIELD_W-1:0] r_s3_fees;
    logic [FIELD_W-1:0] r_s3_lat;
    logic signed [SCORE_W-1:0] r_s3_score;
    logic [SCORE_W-1:0] n_s3_score;

    // running best
    logic               r_have;
    logic [IDX_W-1:0]   r_best_idx;
    logic [FIELD_W-1:0] r_best_fees;
    logic [FIELD_W-1:0] r_best_lat;
    logic signed [SCORE_W-1:0] r_best_score;
    logic               w_beats;
    logic               w_take;

    // output register
    logic               r_out_valid;
    logic [3:0]         r_out_idx;
    logic               r_out_found;
    logic [IDX_W+3:0]   w_best_wide;

    assign w_wr_wide = {{IDX_W{1'b0}}, i_venue_index};
    assign w_wr_addr = w_wr_wide[IDX_W-1:0];
    assign w_wr_en   = i_cmd.write && (w_wr_wide < (IDX_W+4)'(VENUES));

    // table fields have no reset; present bits guard every read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= '{available: i_venue_available,
                                  fees:      i_venue_fees,
                                  latency:   i_venue_latency,
                                  liquidity: i_venue_liquidity};
        end
        if (i_cmd.step) begin
            r_s1_ent <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present  <= '0;
            r_strategy <= STRAT_BALANCED;
            r_addr     <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_have     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_present[w_wr_addr] <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_strategy <= t_strategy'(i_cfg_strategy);
            end
            if (i_cmd.start) begin
                r_addr <= '0;
            end else if (i_cmd.step) begin
                r_addr <= r_addr + 1'b1;
            end
            r_s1_valid <= i_cmd.step;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            if (i_cmd.start) begin
                r_have <= 1'b0;
            end else if (w_take) begin
                r_have <= 1'b1;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign n_s3_score = SCORE_W'(r_s2_liq_w) - SCORE_W'(r_s2_fees) - SCORE_W'(r_s2_lat_w);

    always_comb begin
        case (r_strategy)
            STRAT_COST:     w_beats = (r_s3_fees < r_best_fees);
            STRAT_LATENCY:  w_beats = (r_s3_lat < r_best_lat);
            STRAT_BALANCED: w_beats = (r_s3_score > r_best_score);
            default:        w_beats = 1'b0;
        endcase
    end

    // first present entry seeds the best; later ones must be available and win
    assign w_take = r_s3_valid && r_s3_present && (!r_have || (r_s3_avail && w_beats));

    assign w_best_wide = {4'b0000, r_best_idx};

    always_ff @(posedge i_clk) begin
        r_s1_present <= r_present[r_addr];
        r_s1_idx     <= r_addr;

        r_s2_present <= r_s1_present;
        r_s2_avail   <= r_s1_ent.available;
        r_s2_idx     <= r_s1_idx;
        r_s2_fees    <= r_s1_ent.fees;
        r_s2_lat     <= r_s1_ent.latency;
        r_s2_liq_w   <= LIQ_PROD_W'(r_s1_ent.liquidity) * LIQ_PROD_W'(LIQ_WEIGHT);
        r_s2_lat_w   <= LAT_PROD_W'(r_s1_ent.latency) * LAT_PROD_W'(LAT_WEIGHT);

        r_s3_present <= r_s2_present;
        r_s3_avail   <= r_s2_avail;
        r_s3_idx     <= r_s2_idx;
        r_s3_fees    <= r_s2_fees;
        r_s3_lat     <= r_s2_lat;
        r_s3_score   <= $signed(n_s3_score);

        if (w_take) begin
            r_best_idx   <= r_s3_idx;
            r_best_fees  <= r_s3_fees;
            r_best_lat   <= r_s3_lat;
            r_best_score <= r_s3_score;
        end

        if (i_cmd.load) begin
            r_out_idx   <= r_have ? w_best_wide[3:0] : 4'd0;
            r_out_found <= r_have;
        end
    end

    assign o_sts.last     = (r_addr == IDX_W'(VENUES - 1));
    assign o_sts.busy     = r_s1_valid || r_s2_valid || r_s3_valid;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_best_index = r_out_idx;
    assign o_found      = r_out_found;

endmodule

@@ rtl/core/best_venue_selector_core.sv @@
// Best venue selector.
// Input channel (i_in_valid / o_in_ready) carries one beat per item. A beat
// with i_func = update writes entry i_venue_index of the venue table and marks
// it present (an index beyond the table is dropped); it yields no result.
// A beat with i_func = select issues the scan start in its accepting cycle,
// then scans the table one entry per cycle through the single table read
// port, drains the multiply / score / compare pipeline and loads the output
// register. The input channel takes no new beat until that result is
// loaded; updates go at one per cycle while no select is in progress.
// Output channel (o_out_valid / i_out_ready) carries o_best_index and o_found,
// held in an output register. A stalled receiver does not block updates; a
// following select holds in its drain phase until the waiting result beat is
// taken.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes the strategy
// register; write it only while the block is idle.
// Reset (synchronous, active low) empties the table, drops any pending
// result and sets the strategy to balanced.
module best_venue_selector_core
    import bvs_pkg::*;
#(
    parameter int unsigned VENUES = VENUES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_strategy,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_func,
    input  logic [3:0]         i_venue_index,
    input  logic               i_venue_available,
    input  logic [FIELD_W-1:0] i_venue_fees,
    input  logic [FIELD_W-1:0] i_venue_latency,
    input  logic [FIELD_W-1:0] i_venue_liquidity,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_best_index,
    output logic               o_found
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // the strategy register is a plain flop, so a write always lands
    assign o_cfg_ready = 1'b1;

    // sequence the scan: start, step through every entry, drain, load result
    bvs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // table, compare pipeline, running best and output register
    bvs_dp #(
        .VENUES (VENUES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_strategy    (i_cfg_strategy),
        .i_venue_index     (i_venue_index),
        .i_venue_available (i_venue_available),
        .i_venue_fees      (i_venue_fees),
        .i_venue_latency   (i_venue_latency),
        .i_venue_liquidity (i_venue_liquidity),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_best_index      (o_best_index),
        .o_found           (o_found)
    );

    // an empty table reports index zero
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_best_index == 4'd0))
        else $error("not-found result with nonzero index");

    // an accepted select closes the input channel for the scan
    a_select_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_func == FUNC_SELECT)) |=> !o_in_ready)
        else $error("input accepted during scan");

    // a result beat appears only at the end of a scan
    a_result_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a scan");

    // the result is loaded only when the scan pipeline has drained
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!w_sts.busy && !w_cmd.step))
        else $error("result loaded before pipeline drained");

endmodule

@@ test/tb_best_venue_selector_core.sv @@
module tb_best_venue_selector_core;
    timeunit 1ns;
    timeprecision 1ps;

    import bvs_pkg::*;

    // A select scans every entry, then drains the compare pipeline.
    localparam int unsigned SCAN_CYCLES   = VENUES_DEF + 4;
    localparam int unsigned SETTLE_CYCLES = SCAN_CYCLES + 10;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned PHASES        = 6;
    localparam int unsigned PHASE_BEATS   = 75;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef struct packed {
        logic [3:0] best_index;
        logic       found;
    } t_pick;

    typedef struct {
        logic               func;
        logic [3:0]         index;
        logic               available;
        logic [FIELD_W-1:0] fees;
        logic [FIELD_W-1:0] latency;
        logic [FIELD_W-1:0] liquidity;
    } t_beat;

    typedef enum {ROW_UPDATE, ROW_SELECT, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind kind;
        t_beat     beat;
        t_strategy strategy;
        bit        typed;    // want holds a hand-written expectation
        t_pick     want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_strategy = STRAT_BALANCED;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_func = FUNC_UPDATE;
    logic [3:0]         i_venue_index = '0;
    logic               i_venue_available = 1'b0;
    logic [FIELD_W-1:0] i_venue_fees = '0;
    logic [FIELD_W-1:0] i_venue_latency = '0;
    logic [FIELD_W-1:0] i_venue_liquidity = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [3:0]         o_best_index;
    logic               o_found;

    // Shadow copy of the venue table and the strategy register.
    t_strategy   strategy_now = STRAT_BALANCED;
    bit          present_tbl [VENUES_DEF];
    t_entry      venue_tbl [VENUES_DEF];

    t_pick       pending_picks[$];   // one per accepted select, oldest first
    t_row        plan[$];            // directed stimulus table
    int unsigned fail_count = 0;
    bit          hold_req = 1'b0;    // ask the receiver for one long hold-off

    best_venue_selector_core #(
        .VENUES(VENUES_DEF)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_strategy   (i_cfg_strategy),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_func           (i_func),
        .i_venue_index    (i_venue_index),
        .i_venue_available(i_venue_available),
        .i_venue_fees     (i_venue_fees),
        .i_venue_latency  (i_venue_latency),
        .i_venue_liquidity(i_venue_liquidity),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_best_index     (o_best_index),
        .o_found          (o_found)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

    // Score in 64-bit signed arithmetic; the fields are zero-extended first.
    function automatic longint venue_score(int unsigned i);
        longint liq, fee, lat;
        liq = venue_tbl[i].liquidity;
        fee = venue_tbl[i].fees;
        lat = venue_tbl[i].latency;
        return liq * LIQ_WEIGHT - fee - lat * LAT_WEIGHT;
    endfunction

    // Strict improvement only, so on a tie the lower index stays.
    function automatic bit improves(int unsigned cand, int unsigned best);
        case (strategy_now)
            STRAT_COST:     return venue_tbl[cand].fees < venue_tbl[best].fees;
            STRAT_LATENCY:  return venue_tbl[cand].latency < venue_tbl[best].latency;
            STRAT_BALANCED: return venue_score(cand) > venue_score(best);
            default:        return 1'b0;
        endcase
    endfunction

    // Walk the table in index order. The first present entry seeds the best,
    // available or not; later entries must be available to replace it.
    function automatic t_pick pick_best_venue();
        t_pick p;
        bit    have;
        p    = '0;
        have = 1'b0;
        for (int i = 0; i < VENUES_DEF; i++) begin
            if (!present_tbl[i])
                continue;
            if (!have) begin
                p.best_index = 4'(i);
                p.found      = 1'b1;
                have         = 1'b1;
            end else if (venue_tbl[i].available && improves(i, 32'(p.best_index))) begin
                p.best_index = 4'(i);
            end
        end
        return p;
    endfunction

    function automatic void plan_update(logic [3:0] idx, logic avail,
                                        logic [FIELD_W-1:0] fees,
                                        logic [FIELD_W-1:0] latency,
                                        logic [FIELD_W-1:0] liquidity);
        t_row r;
        r.kind     = ROW_UPDATE;
        r.beat     = '{FUNC_UPDATE, idx, avail, fees, latency, liquidity};
        r.strategy = STRAT_BALANCED;
        r.typed    = 1'b0;
        r.want     = '0;
        plan = {plan, r};
    endfunction

    function automatic void plan_select(bit typed, logic [3:0] idx, logic found);
        t_row r;
        r.kind     = ROW_SELECT;
        r.beat     = '{FUNC_SELECT, 4'd0, 1'b0, '0, '0, '0};
        r.strategy = STRAT_BALANCED;
        r.typed    = typed;
        r.want     = '{idx, found};
        plan = {plan, r};
    endfunction

    function automatic void plan_config(t_strategy s);
        t_row r;
        r.kind     = ROW_CONFIG;
        r.beat     = '{FUNC_UPDATE, 4'd0, 1'b0, '0, '0, '0};
        r.strategy = s;
        r.typed    = 1'b0;
        r.want     = '0;
        plan = {plan, r};
    endfunction

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [FIELD_W-1:0] random_field();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return FIELD_MAX;
            2:       return $urandom_range(0, 3);   // small values make ties likely
            default: return $urandom();
        endcase
    endfunction

    function automatic t_beat random_beat();
        t_beat b;
        b.func      = ($urandom_range(0, 99) < 35) ? FUNC_SELECT : FUNC_UPDATE;
        b.index     = 4'($urandom_range(0, VENUES_DEF - 1));
        b.available = ($urandom_range(0, 3) != 0);
        b.fees      = random_field();
        b.latency   = random_field();
        b.liquidity = random_field();
        return b;
    endfunction

    // Offer one beat and hold it until accepted. Valid stays high on return:
    // the caller either offers the next beat in the same step or drops valid.
    task automatic run_beat(t_beat b, int unsigned gap, bit typed, t_pick want);
        t_pick exp_pick;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_func            <= b.func;
        i_venue_index     <= b.index;
        i_venue_available <= b.available;
        i_venue_fees      <= b.fees;
        i_venue_latency   <= b.latency;
        i_venue_liquidity <= b.liquidity;
        do @(posedge i_clk); while (!o_in_ready);
        if (b.func == FUNC_UPDATE) begin
            if (b.index < VENUES_DEF) begin
                present_tbl[b.index] = 1'b1;
                venue_tbl[b.index]   = '{b.available, b.fees, b.latency, b.liquidity};
            end
        end else begin
            exp_pick      = typed ? want : pick_best_venue();
            pending_picks = {pending_picks, exp_pick};
        end
    endtask

    // Drain all results, let a trailing update settle, then write the register.
    task automatic write_strategy(t_strategy s);
        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_strategy <= s;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        strategy_now = s;
    endtask

    initial begin : stimulus
        t_pick none;
        none = '0;

        // Empty table, then an unavailable entry that still seeds the best.
        plan_select(1'b1, 4'd0, 1'b0);
        plan_update(4'd5, 1'b0, '0, '0, '0);
        plan_select(1'b1, 4'd5, 1'b1);
        // All fields at their maximum: the score stays positive.
        plan_update(4'd15, 1'b1, FIELD_MAX, FIELD_MAX, FIELD_MAX);
        plan_select(1'b1, 4'd15, 1'b1);
        plan_update(4'd0, 1'b1, '0, '0, FIELD_MAX);
        plan_select(1'b1, 4'd0, 1'b1);
        // Most negative score, and a tie with entry 0 that must lose.
        plan_update(4'd3, 1'b1, FIELD_MAX, FIELD_MAX, '0);
        plan_update(4'd7, 1'b1, '0, '0, FIELD_MAX);
        plan_select(1'b1, 4'd0, 1'b1);
        // Entry 0 goes unavailable with the worst score but still seeds.
        plan_update(4'd0, 1'b0, FIELD_MAX, FIELD_MAX, '0);
        plan_select(1'b1, 4'd7, 1'b1);
        plan_config(STRAT_COST);
        plan_update(4'd1, 1'b1, 32'd1, '0, 32'd5);
        plan_select(1'b1, 4'd7, 1'b1);
        plan_config(STRAT_LATENCY);
        plan_select(1'b1, 4'd1, 1'b1);
        plan_config(STRAT_PRICE);
        plan_select(1'b1, 4'd0, 1'b1);
        plan_config(STRAT_BALANCED);
        plan_select(1'b0, 4'd0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_CONFIG)
                write_strategy(plan[k].strategy);
            else
                run_beat(plan[k].beat, idle_len(), plan[k].typed, plan[k].want);
        end

        // Random phases: every strategy in turn, then random ones. Open each
        // run of 50 beats with a burst that has no sender gaps.
        for (int p = 0; p < PHASES; p++) begin
            write_strategy(t_strategy'(p < 4 ? p : $urandom_range(0, 3)));
            for (int k = 0; k < PHASE_BEATS; k++) begin
                if (p == 2 && k == 10)
                    hold_req = 1'b1;
                run_beat(random_beat(), (k % 50 < 15) ? 0 : idle_len(), 1'b0, none);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: ready stretches of random length, short and long stalls, and
    // one long hold-off on request so that the block backs up its input.
    initial begin : receiver
        int unsigned n;
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            n = idle_len();
            if (n != 0) begin
                i_out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_pick want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_picks.size() == 0) begin
                $error("result beat with none expected: best_index %0d found %0d",
                       o_best_index, o_found);
                fail_count++;
            end else begin
                want = pending_picks.pop_front();
                if (o_best_index !== want.best_index) begin
                    $error("best_index mismatch: expected %0d actual %0d",
                           want.best_index, o_best_index);
                    fail_count++;
                end
                if (o_found !== want.found) begin
                    $error("found mismatch: expected %0d actual %0d",
                           want.found, o_found);
                    fail_count++;
                end
            end
        end
    end

endmodule
